FILE: rtl/dfa_pkg.sv
// ----------------------------------------------------------------------------
// dfa_pkg
// Shared types, field widths, mode codes and helpers for the word recognizer.
// ----------------------------------------------------------------------------
`default_nettype none

package dfa_pkg;

  localparam int STATE_COUNT_DEF = 16;
  localparam int SYMBOL_BITS_DEF = 8;

  // Fixed field widths of the item and result words
  localparam int MODE_W = 3;
  localparam int SYM_W  = 8;
  localparam int ST_W   = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_TRANS = 3'd0,
    MODE_LOAD_FINAL = 3'd1,
    MODE_LOAD_ALPHA = 3'd2,
    MODE_RUN        = 3'd3,
    MODE_EMPTY      = 3'd4
  } mode_t;

  // One transition table entry: error marker plus destination state
  typedef struct packed {
    logic            err;
    logic [ST_W-1:0] dest;
  } entry_t;

  localparam entry_t ERR_ENTRY = '{err: 1'b1, dest: '0};

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SYM_W-1:0]  symbol;
    logic [ST_W-1:0]   state_index;
    logic [ST_W-1:0]   next_state;
    logic              to_error;
    logic              flag_bit;
    logic              last;
  } item_t;

  typedef struct packed {
    logic            accepted;
    logic [ST_W-1:0] end_state;
    logic            ended_in_error;
  } result_t;

  // Write command into the table / alphabet memory
  typedef struct packed {
    logic             trans_en;
    logic             alpha_en;
    logic [SYM_W-1:0] sym;
    logic [ST_W-1:0]  lane;
    entry_t           entry;
    logic             alpha_bit;
  } tmem_wr_t;

  // Number of table lanes: only states a 4-bit field can name are stored
  function automatic int lane_count(int state_count);
    return (state_count < (1 << ST_W)) ? state_count : (1 << ST_W);
  endfunction

  function automatic logic state_ok(logic [ST_W-1:0] s, int state_count);
    return int'(s) < state_count;
  endfunction

  function automatic logic sym_ok(logic [SYM_W-1:0] s, int symbol_bits);
    return (s >> symbol_bits) == '0;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/dfa_if.sv
// ----------------------------------------------------------------------------
// dfa_if
// Valid/ready channels for input items and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfa_item_if import dfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [SYM_W-1:0]  symbol;
  logic [ST_W-1:0]   state_index;
  logic [ST_W-1:0]   next_state;
  logic              to_error;
  logic              flag_bit;
  logic              last;

  modport source (
    output valid, mode, symbol, state_index, next_state, to_error, flag_bit, last,
    input  ready
  );
  modport sink (
    input  valid, mode, symbol, state_index, next_state, to_error, flag_bit, last,
    output ready
  );
endinterface

interface dfa_result_if import dfa_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            accepted;
  logic [ST_W-1:0] end_state;
  logic            ended_in_error;

  modport source (output valid, accepted, end_state, ended_in_error, input ready);
  modport sink   (input valid, accepted, end_state, ended_in_error, output ready);
endinterface

`default_nettype wire

FILE: rtl/dfa_word_recognizer_top.sv
// ----------------------------------------------------------------------------
// dfa_word_recognizer_top
// Table-driven deterministic automaton that recognizes words of symbols.
// ----------------------------------------------------------------------------
// The block takes one item per clock except during the clear sweep and
// while a held result blocks the item register. The item register is
// loaded at the edge that takes the item; the result register is loaded
// from it when that item moves on, and the sink can take the result once
// it shows. The rate is set by the loop from the current-state register
// through the lane select of the table row back to that register: the row
// for a symbol is read from memory when the item is taken, and the state
// picks its entry in the next cycle. A result held by the sink keeps a
// word-ending item in the item register, and item.ready stays low until
// the result register frees up. After reset the table and alphabet memory
// is swept to "error" / "not in alphabet", one row per cycle, and
// item.ready stays low meanwhile (start_state writes are taken as usual).
// Loads take effect for every item taken after them, also in the middle of
// a word. Symbols outside the alphabet or error moves make the word fail for
// good; the last symbol or an empty-word item ends it, reports accepted /
// end_state / ended_in_error, and the next word restarts at start_state.
// The user must write start_state only while the block is idle (unchecked).
// ----------------------------------------------------------------------------
`default_nettype none

module dfa_word_recognizer_top import dfa_pkg::*; #(
  parameter int STATE_COUNT = STATE_COUNT_DEF,
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [ST_W-1:0] cfg_wdata,
  dfa_item_if.sink        item,
  dfa_result_if.source    result
);

  localparam int LANES = lane_count(STATE_COUNT);

  logic [ST_W-1:0]    start_state;
  item_t              in_pkt;
  logic               accept;

  // Stage register (item being stepped)
  logic               s1_valid;
  item_t              s1_item;
  logic               s1_fire;

  // Result register
  logic               out_valid;
  result_t            out_res;
  logic               out_free;

  tmem_wr_t           wr;
  entry_t [LANES-1:0] row;
  logic               alpha;
  logic               busy;
  logic               has_result;
  result_t            res;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_state <= '0;
    end else if (cfg_we) begin
      start_state <= cfg_wdata;
    end
  end

  always_comb begin
    in_pkt.mode        = item.mode;
    in_pkt.symbol      = item.symbol;
    in_pkt.state_index = item.state_index;
    in_pkt.next_state  = item.next_state;
    in_pkt.to_error    = item.to_error;
    in_pkt.flag_bit    = item.flag_bit;
    in_pkt.last        = item.last;
  end

  // Handshake: the stage frees up whenever its item moves on
  assign out_free   = !out_valid || result.ready;
  assign s1_fire    = s1_valid && (!has_result || out_free);
  assign item.ready = !busy && (!s1_valid || s1_fire);
  assign accept     = item.valid && item.ready;

  // Table and alphabet writes happen as the load word is taken, so that a
  // run word taken next cycle already reads the new row.
  always_comb begin
    wr.trans_en  = accept && (in_pkt.mode == MODE_LOAD_TRANS) &&
                   state_ok(in_pkt.state_index, STATE_COUNT) &&
                   sym_ok(in_pkt.symbol, SYMBOL_BITS);
    wr.alpha_en  = accept && (in_pkt.mode == MODE_LOAD_ALPHA) &&
                   sym_ok(in_pkt.symbol, SYMBOL_BITS);
    wr.sym       = in_pkt.symbol;
    wr.lane      = in_pkt.state_index;
    wr.entry.err = in_pkt.to_error || !state_ok(in_pkt.next_state, STATE_COUNT);
    wr.entry.dest = wr.entry.err ? '0 : in_pkt.next_state;
    wr.alpha_bit = in_pkt.flag_bit;
  end

  dfa_tmem #(
    .STATE_COUNT(STATE_COUNT),
    .SYMBOL_BITS(SYMBOL_BITS)
  ) u_tmem (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd_en    (accept),
    .rd_sym   (in_pkt.symbol),
    .rd_row   (row),
    .rd_alpha (alpha),
    .busy     (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_pkt;
    end
  end

  dfa_word #(
    .STATE_COUNT(STATE_COUNT),
    .SYMBOL_BITS(SYMBOL_BITS)
  ) u_word (
    .clk         (clk),
    .rst         (rst),
    .fire        (s1_fire),
    .s1          (s1_item),
    .row         (row),
    .alpha       (alpha),
    .start_state (start_state),
    .has_result  (has_result),
    .res         (res)
  );

  // Result register; holds while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && has_result) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && has_result) begin
      out_res <= res;
    end
  end

  assign result.valid          = out_valid;
  assign result.accepted       = out_res.accepted;
  assign result.end_state      = out_res.end_state;
  assign result.ended_in_error = out_res.ended_in_error;

endmodule

`default_nettype wire

FILE: rtl/dfa_tmem.sv
// ----------------------------------------------------------------------------
// dfa_tmem
// Transition table and alphabet bits, one row per symbol, with a clearing
// sweep after reset and a registered row read.
// ----------------------------------------------------------------------------
`default_nettype none

module dfa_tmem import dfa_pkg::*; #(
  parameter int STATE_COUNT = STATE_COUNT_DEF,
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tmem_wr_t                            wr,
  input  logic                                rd_en,
  input  logic [SYM_W-1:0]                    rd_sym,
  output entry_t [lane_count(STATE_COUNT)-1:0] rd_row,
  output logic                                rd_alpha,
  output logic                                busy
);

  localparam int LANES  = lane_count(STATE_COUNT);
  localparam int LANE_W = $clog2(LANES);
  localparam int ROWS   = 1 << SYMBOL_BITS;

  entry_t [LANES-1:0]     tab   [ROWS];
  logic                   abits [ROWS];
  logic [SYMBOL_BITS-1:0] clr_cnt;

  // Clear sweep: one row per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_cnt <= '0;
    end else if (busy) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == SYMBOL_BITS'(ROWS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      tab[clr_cnt]   <= {LANES{ERR_ENTRY}};
      abits[clr_cnt] <= 1'b0;
    end else begin
      if (wr.trans_en) begin
        tab[wr.sym[SYMBOL_BITS-1:0]][wr.lane[LANE_W-1:0]] <= wr.entry;
      end
      if (wr.alpha_en) begin
        abits[wr.sym[SYMBOL_BITS-1:0]] <= wr.alpha_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row   <= tab[rd_sym[SYMBOL_BITS-1:0]];
      rd_alpha <= abits[rd_sym[SYMBOL_BITS-1:0]];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dfa_word.sv
// ----------------------------------------------------------------------------
// dfa_word
// Word state (current state, sticky fail, in-word) and final flags; one step
// of the automaton per run item in the stage register.
// ----------------------------------------------------------------------------
`default_nettype none

module dfa_word import dfa_pkg::*; #(
  parameter int STATE_COUNT = STATE_COUNT_DEF,
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                fire,
  input  item_t                               s1,
  input  entry_t [lane_count(STATE_COUNT)-1:0] row,
  input  logic                                alpha,
  input  logic [ST_W-1:0]                     start_state,
  output logic                                has_result,
  output result_t                             res
);

  localparam int LANES  = lane_count(STATE_COUNT);
  localparam int LANE_W = $clog2(LANES);

  logic [ST_W-1:0]  cur_state;
  logic             failed;
  logic             in_word;
  logic [LANES-1:0] final_flags;

  logic            is_run;
  logic            is_empty;
  logic            end_word;
  logic [ST_W-1:0] base_state;
  logic            base_fail;
  logic            base_ok;
  entry_t          ent;
  logic            step_fail;
  logic [ST_W-1:0] state_next;
  logic            failed_next;
  logic            err;
  logic            fin;

  always_comb begin
    is_run     = (s1.mode == MODE_RUN);
    is_empty   = (s1.mode == MODE_EMPTY);
    end_word   = is_empty || (is_run && s1.last);
    has_result = end_word;

    // A new word starts from the configured start state
    base_state = in_word ? cur_state : start_state;
    base_fail  = in_word ? failed : !state_ok(start_state, STATE_COUNT);
    base_ok    = state_ok(base_state, STATE_COUNT);

    ent       = base_ok ? row[base_state[LANE_W-1:0]] : ERR_ENTRY;
    step_fail = !sym_ok(s1.symbol, SYMBOL_BITS) || !alpha || !base_ok || ent.err;

    state_next  = (is_run && !base_fail && !step_fail) ? ent.dest : base_state;
    failed_next = base_fail || (is_run && step_fail);

    err = failed_next || !state_ok(state_next, STATE_COUNT);
    fin = err ? 1'b0 : final_flags[state_next[LANE_W-1:0]];

    res.accepted       = fin;
    res.end_state      = err ? '0 : state_next;
    res.ended_in_error = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_word   <= 1'b0;
      cur_state <= '0;
      failed    <= 1'b0;
    end else if (fire && (is_run || is_empty)) begin
      if (end_word) begin
        in_word   <= 1'b0;
        cur_state <= '0;
        failed    <= 1'b0;
      end else begin
        in_word   <= 1'b1;
        cur_state <= state_next;
        failed    <= failed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      final_flags <= '0;
    end else if (fire && s1.mode == MODE_LOAD_FINAL &&
                 state_ok(s1.state_index, STATE_COUNT)) begin
      final_flags[s1.state_index[LANE_W-1:0]] <= s1.flag_bit;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dfa_chk.sv
// ----------------------------------------------------------------------------
// dfa_chk
// Port-level checks for the word recognizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dfa_chk import dfa_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic            accepted,
  input logic [ST_W-1:0] end_state,
  input logic            ended_in_error
);

  // Clear sweep keeps the input closed right after reset
  a_busy_after_rst: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input open right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable({accepted, end_state, ended_in_error}))
    else $error("stalled result changed");

  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && ended_in_error |-> end_state == '0 && !accepted)
    else $error("error result with state or accept set");

  // A fresh result comes from an input item that passed through the item register
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching input word");

endmodule

bind dfa_word_recognizer_top dfa_chk u_chk (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (item.valid),
  .in_ready       (item.ready),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .accepted       (result.accepted),
  .end_state      (result.end_state),
  .ended_in_error (result.ended_in_error)
);

`default_nettype wire
